FILE: hw/rtl/ssm_pkg.sv
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared codes and the control/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ssm_pkg;

	localparam int ACT_W = 2;
	localparam int OP_W  = 2;

	localparam logic [ACT_W-1:0] ACT_LOAD_A  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_LOAD_B  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd2;

	localparam logic [OP_W-1:0] OP_INTERSECT = 2'd0;
	localparam logic [OP_W-1:0] OP_UNION     = 2'd1;
	localparam logic [OP_W-1:0] OP_A_MINUS_B = 2'd2;
	localparam logic [OP_W-1:0] OP_SYMDIFF   = 2'd3;

	typedef struct packed {
		logic load_a;
		logic load_b;
		logic step;
		logic finish;
	} ssm_cmd_t;

	typedef struct packed {
		logic walk_done;
		logic out_free;
	} ssm_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ssm_if.sv
// ----------------------------------------------------------------------------
// ssm_if
// Valid/ready channels: input items and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssm_item_if #(
	parameter int ELEMENT_WIDTH = 16
);
	logic                            valid;
	logic                            ready;
	logic [ssm_pkg::ACT_W-1:0]       action;
	logic signed [ELEMENT_WIDTH-1:0] element;

	modport source (output valid, output action, output element, input ready);
	modport sink   (input valid, input action, input element, output ready);
endinterface

interface ssm_result_if #(
	parameter int ELEMENT_WIDTH = 16
);
	logic                            valid;
	logic                            ready;
	logic signed [ELEMENT_WIDTH-1:0] result_value;
	logic                            is_last;
	logic                            is_empty;
	logic                            overflowed;

	modport source (output valid, output result_value, output is_last, output is_empty,
		output overflowed, input ready);
	modport sink   (input valid, input result_value, input is_last, input is_empty,
		input overflowed, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ssm_ctrl.sv
// ----------------------------------------------------------------------------
// ssm_ctrl
// Sequencer: takes loads while idle, runs the merge walk and the final beat.
// ----------------------------------------------------------------------------
`default_nettype none

module ssm_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	input  wire logic [ssm_pkg::ACT_W-1:0] in_action,
	output logic                           in_ready,
	input  wire ssm_pkg::ssm_status_t      status,
	output ssm_pkg::ssm_cmd_t              cmd
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_WALK  = 3'b010,
		ST_FLUSH = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.load_a = accept && (in_action == ssm_pkg::ACT_LOAD_A);
		cmd.load_b = accept && (in_action == ssm_pkg::ACT_LOAD_B);
		case (state_q)
			ST_IDLE: begin
				if (accept && (in_action == ssm_pkg::ACT_COMPUTE)) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (status.walk_done) begin
					state_d = ST_FLUSH;
				end else begin
					cmd.step = status.out_free;
				end
			end
			ST_FLUSH: begin
				cmd.finish = status.out_free;
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/ssm_dp.sv
// ----------------------------------------------------------------------------
// ssm_dp
// Set stores, merge heads and compare, one-deep hold and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ssm_dp #(
	parameter int SET_DEPTH     = 32,
	parameter int ELEMENT_WIDTH = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [ssm_pkg::OP_W-1:0]        cfg_wdata,
	input  wire logic signed [ELEMENT_WIDTH-1:0] element,
	input  wire ssm_pkg::ssm_cmd_t               cmd,
	output ssm_pkg::ssm_status_t                 status,
	ssm_result_if.source                         results
);

	localparam int CNT_W = $clog2(SET_DEPTH + 1);
	localparam int IDX_W = $clog2(SET_DEPTH);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(SET_DEPTH);

	logic signed [ELEMENT_WIDTH-1:0] store_a_q [SET_DEPTH];
	logic signed [ELEMENT_WIDTH-1:0] store_b_q [SET_DEPTH];

	logic [CNT_W-1:0]          count_a_q, count_b_q;
	logic [CNT_W-1:0]          ia_q, ib_q;
	logic                      dropped_q;
	logic [ssm_pkg::OP_W-1:0]  op_q;
	logic signed [ELEMENT_WIDTH-1:0] held_q;
	logic                      held_valid_q;
	logic                      out_valid_q;
	logic signed [ELEMENT_WIDTH-1:0] out_value_q;
	logic                      out_last_q, out_empty_q, out_ovf_q;

	logic                            a_left, b_left;
	logic signed [ELEMENT_WIDTH-1:0] head_a, head_b;
	logic                            take_a, take_b, take_both;
	logic                            emit_a_only, emit_b_only, emit_both, emit;
	logic                            out_load;

	always_comb begin
		a_left      = ia_q < count_a_q;
		b_left      = ib_q < count_b_q;
		head_a      = store_a_q[ia_q[IDX_W-1:0]];
		head_b      = store_b_q[ib_q[IDX_W-1:0]];
		take_a      = !b_left || (a_left && (head_a < head_b));
		take_b      = !take_a && (!a_left || (head_b < head_a));
		take_both   = !take_a && !take_b;
		emit_a_only = (op_q != ssm_pkg::OP_INTERSECT);
		emit_b_only = (op_q == ssm_pkg::OP_UNION) || (op_q == ssm_pkg::OP_SYMDIFF);
		emit_both   = (op_q == ssm_pkg::OP_INTERSECT) || (op_q == ssm_pkg::OP_UNION);
		emit        = take_a ? emit_a_only : (take_b ? emit_b_only : emit_both);
		out_load    = (cmd.step && emit && held_valid_q) || cmd.finish;
	end

	assign status.walk_done = !a_left && !b_left;
	assign status.out_free  = !out_valid_q || results.ready;

	assign results.valid        = out_valid_q;
	assign results.result_value = out_value_q;
	assign results.is_last      = out_last_q;
	assign results.is_empty     = out_empty_q;
	assign results.overflowed   = out_ovf_q;

	always_ff @(posedge clk) begin
		if (cmd.load_a && (count_a_q != FULL)) begin
			store_a_q[count_a_q[IDX_W-1:0]] <= element;
		end
		if (cmd.load_b && (count_b_q != FULL)) begin
			store_b_q[count_b_q[IDX_W-1:0]] <= element;
		end
		if (cmd.step && emit) begin
			held_q <= take_b ? head_b : head_a;
		end
		if (cmd.finish) begin
			out_value_q <= held_valid_q ? held_q : '0;
			out_last_q  <= 1'b1;
			out_empty_q <= !held_valid_q;
			out_ovf_q   <= dropped_q;
		end else if (out_load) begin
			out_value_q <= held_q;
			out_last_q  <= 1'b0;
			out_empty_q <= 1'b0;
			out_ovf_q   <= dropped_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q         <= ssm_pkg::OP_INTERSECT;
			count_a_q    <= '0;
			count_b_q    <= '0;
			dropped_q    <= 1'b0;
			ia_q         <= '0;
			ib_q         <= '0;
			held_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				op_q <= cfg_wdata;
			end
			if (cmd.load_a) begin
				if (count_a_q == FULL) begin
					dropped_q <= 1'b1;
				end else begin
					count_a_q <= count_a_q + CNT_W'(1);
				end
			end
			if (cmd.load_b) begin
				if (count_b_q == FULL) begin
					dropped_q <= 1'b1;
				end else begin
					count_b_q <= count_b_q + CNT_W'(1);
				end
			end
			if (cmd.step) begin
				if (take_a || take_both) begin
					ia_q <= ia_q + CNT_W'(1);
				end
				if (take_b || take_both) begin
					ib_q <= ib_q + CNT_W'(1);
				end
				if (emit) begin
					held_valid_q <= 1'b1;
				end
			end
			if (cmd.finish) begin
				count_a_q    <= '0;
				count_b_q    <= '0;
				dropped_q    <= 1'b0;
				ia_q         <= '0;
				ib_q         <= '0;
				held_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/sorted_set_merge_operations.sv
// ----------------------------------------------------------------------------
// sorted_set_merge_operations
// Loads two ascending sets, then merges them into the selected set operation.
//
//   channel   dir  payload                                          beat
//   items     in   action, element                                  valid & ready
//   results   out  result_value, is_last, is_empty, overflowed      valid & ready
//   cfg       in   cfg_wdata (set_operation)                        cfg_we
//
// A load is taken on its beat; a new item may follow at once.
// After its beat a compute holds off items through the merge walk (one merge step
// per cycle while results.ready is high or the output register is empty), the end
// of walk and then the closing beat.
// Items are refused from the compute beat until the closing beat is registered.
// Reset empties both sets and sets the operation to intersection.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_set_merge_operations #(
	parameter int SET_DEPTH     = 32,
	parameter int ELEMENT_WIDTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	ssm_item_if.sink                      items,
	ssm_result_if.source                  results,
	input  wire logic                     cfg_we,
	input  wire logic [ssm_pkg::OP_W-1:0] cfg_wdata
);

	ssm_pkg::ssm_cmd_t    cmd;
	ssm_pkg::ssm_status_t status;
	logic                 in_ready;

	assign items.ready = in_ready;

	ssm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.in_action (items.action),
		.in_ready  (in_ready),
		.status    (status),
		.cmd       (cmd)
	);

	ssm_dp #(
		.SET_DEPTH     (SET_DEPTH),
		.ELEMENT_WIDTH (ELEMENT_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.element   (items.element),
		.cmd       (cmd),
		.status    (status),
		.results   (results)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/ssm_checker.sv
// ----------------------------------------------------------------------------
// ssm_checker
// Port-level checks on the merge block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ssm_checker #(
	parameter int ELEMENT_WIDTH = 16
) (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      in_valid,
	input wire logic                      in_ready,
	input wire logic [ssm_pkg::ACT_W-1:0] in_action,
	input wire logic                      out_valid,
	input wire logic                      out_ready,
	input wire logic [ELEMENT_WIDTH-1:0]  out_value,
	input wire logic                      out_last,
	input wire logic                      out_empty,
	input wire logic                      out_ovf
);

	// stalled beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_last)
			&& $stable(out_empty) && $stable(out_ovf))
		else $error("result beat changed while stalled");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_empty |-> out_last)
		else $error("empty result not marked last");

	a_compute_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_action == ssm_pkg::ACT_COMPUTE) |=> !in_ready)
		else $error("items taken during a compute");

	a_mid_result_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> !in_ready)
		else $error("items taken before the closing beat");

endmodule

bind sorted_set_merge_operations ssm_checker #(
	.ELEMENT_WIDTH (ELEMENT_WIDTH)
) u_ssm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (items.valid),
	.in_ready  (items.ready),
	.in_action (items.action),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_value (results.result_value),
	.out_last  (results.is_last),
	.out_empty (results.is_empty),
	.out_ovf   (results.overflowed)
);

`default_nettype wire

FILE: tb/sv/tb_sorted_set_merge_operations.sv
// ----------------------------------------------------------------------------
// tb_sorted_set_merge_operations
// Loads directed and random sets into both stores and runs every set
// operation. Each result beat is checked against a behavioural merge of the
// same sets, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module tb_sorted_set_merge_operations;
	timeunit 1ns;
	timeprecision 1ps;

	import ssm_pkg::*;

	localparam int SET_DEPTH = 32;
	localparam int ELEM_W    = 16;
	localparam int MAX_GAP   = 14;
	localparam int RANDOM_ITEMS = 16;
	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

	typedef logic signed [ELEM_W-1:0] elem_t;

	typedef struct packed {
		elem_t value;
		logic  is_last;
		logic  is_empty;
		logic  ovf;
	} beat_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            cfg_we = 1'b0;
	logic [OP_W-1:0] cfg_wdata = OP_INTERSECT;

	ssm_item_if   #(.ELEMENT_WIDTH(ELEM_W)) item_ch ();
	ssm_result_if #(.ELEMENT_WIDTH(ELEM_W)) result_ch ();

	sorted_set_merge_operations #(
		.SET_DEPTH(SET_DEPTH),
		.ELEMENT_WIDTH(ELEM_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.items(item_ch),
		.results(result_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// mirror of the block state
	elem_t           mirror_a[$];
	elem_t           mirror_b[$];
	logic [OP_W-1:0] mirror_op = OP_INTERSECT;
	logic            mirror_dropped = 1'b0;

	beat_t expected_beats[$];
	int    mismatches = 0;
	int    items_sent = 0;
	bit    no_idle = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	function automatic void add_beat(input beat_t b);
		expected_beats.insert(expected_beats.size(), b);
	endfunction

	task automatic predict_set_result(input logic [ACT_W-1:0] act, input elem_t el);
		int ia, ib, n;
		bit take_a, take_b, take_both;
		ia = 0;
		ib = 0;
		n = 0;
		take_a    = (mirror_op != OP_INTERSECT);
		take_b    = (mirror_op == OP_UNION) || (mirror_op == OP_SYMDIFF);
		take_both = (mirror_op == OP_INTERSECT) || (mirror_op == OP_UNION);
		case (act)
			ACT_LOAD_A: begin
				if (mirror_a.size() < SET_DEPTH) mirror_a.insert(mirror_a.size(), el);
				else mirror_dropped = 1'b1;
			end
			ACT_LOAD_B: begin
				if (mirror_b.size() < SET_DEPTH) mirror_b.insert(mirror_b.size(), el);
				else mirror_dropped = 1'b1;
			end
			ACT_COMPUTE: begin
				while (ia < mirror_a.size() || ib < mirror_b.size()) begin
					if (ib >= mirror_b.size() ||
					    (ia < mirror_a.size() && mirror_a[ia] < mirror_b[ib])) begin
						if (take_a) begin
							add_beat('{mirror_a[ia], 1'b0, 1'b0, mirror_dropped});
							n++;
						end
						ia++;
					end else if (ia >= mirror_a.size() || mirror_b[ib] < mirror_a[ia]) begin
						if (take_b) begin
							add_beat('{mirror_b[ib], 1'b0, 1'b0, mirror_dropped});
							n++;
						end
						ib++;
					end else begin
						if (take_both) begin
							add_beat('{mirror_a[ia], 1'b0, 1'b0, mirror_dropped});
							n++;
						end
						ia++;
						ib++;
					end
				end
				if (n == 0) add_beat('{'0, 1'b1, 1'b1, mirror_dropped});
				else expected_beats[expected_beats.size()-1].is_last = 1'b1;
				mirror_a.delete();
				mirror_b.delete();
				mirror_dropped = 1'b0;
			end
			default: ;
		endcase
	endtask

	task automatic send_item(input logic [ACT_W-1:0] act, input elem_t el);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid   <= 1'b1;
		item_ch.action  <= act;
		item_ch.element <= el;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		if (act != ACT_UNUSED) items_sent++;
		predict_set_result(act, el);
	endtask

	task automatic wait_drained();
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_op(input logic [OP_W-1:0] op);
		item_ch.valid <= 1'b0;
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= op;
		@(posedge clk);
		cfg_we    <= 1'b0;
		mirror_op = op;
	endtask

	task automatic report(input string what, input beat_t want, input beat_t got);
		mismatches++;
		if (mismatches <= 10)
			$display({"%s: expected value %0d last %0b empty %0b ovf %0b, ",
				"got value %0d last %0b empty %0b ovf %0b"},
				what, want.value, want.is_last, want.is_empty, want.ovf,
				got.value, got.is_last, got.is_empty, got.ovf);
	endtask

	// Sets drawn from one ascending pool; each element lands in A, B or both.
	task automatic run_round(input int pool_size, input int step_max, input bit noisy);
		elem_t qa[$], qb[$];
		int    v, span, pick;
		span = pool_size * step_max;
		if (span > 65535) span = 65535;
		v = -32768 + $urandom_range(0, 65535 - span);
		for (int i = 0; i < pool_size && v <= 32767; i++) begin
			pick = $urandom_range(0, 2);
			if (pick != 1) qa.insert(qa.size(), elem_t'(v));
			if (pick != 0) qb.insert(qb.size(), elem_t'(v));
			v += $urandom_range(1, step_max);
		end
		while (qa.size() != 0 || qb.size() != 0) begin
			if (noisy && $urandom_range(0, 7) == 0) send_item(ACT_UNUSED, elem_t'($urandom));
			if (noisy && $urandom_range(0, 7) == 0)
				send_item($urandom_range(0, 1) ? ACT_LOAD_A : ACT_LOAD_B, elem_t'($urandom));
			if (qb.size() == 0 || (qa.size() != 0 && $urandom_range(0, 1)))
				send_item(ACT_LOAD_A, qa.pop_front());
			else
				send_item(ACT_LOAD_B, qb.pop_front());
		end
		send_item(ACT_COMPUTE, elem_t'($urandom));
	endtask

	task automatic test_reset_state();
		send_item(ACT_UNUSED, 16'sh7fff);
		send_item(ACT_COMPUTE, 16'sh8000);
	endtask

	task automatic test_operations();
		for (int op = OP_INTERSECT; op <= OP_SYMDIFF; op++) begin
			set_op(OP_W'(op));
			send_item(ACT_LOAD_A, 16'sh8000);
			send_item(ACT_LOAD_B, 16'sd7);
			send_item(ACT_LOAD_A, 16'sd7);
			send_item(ACT_LOAD_B, 16'sh7fff);
			send_item(ACT_COMPUTE, '1);
		end
	endtask

	task automatic test_unordered_loads();
		elem_t el;
		repeat (3) begin
			set_op(OP_W'($urandom_range(0, 3)));
			repeat ($urandom_range(2, 5)) begin
				el = $urandom_range(0, 1) ? elem_t'($urandom) : elem_t'($urandom_range(0, 15) - 8);
				send_item(ACT_LOAD_A, el);
				if ($urandom_range(0, 1)) send_item(ACT_LOAD_B, el);
			end
			if ($urandom_range(0, 1)) send_item(ACT_LOAD_A, el);
			send_item(ACT_LOAD_B, elem_t'($urandom));
			send_item(ACT_COMPUTE, elem_t'($urandom));
		end
	endtask

	task automatic test_store_full();
		int v;
		set_op(OP_UNION);
		no_idle = 1'b1;
		v = -32768 + $urandom_range(0, 1000);
		for (int i = 0; i < 2 * SET_DEPTH + 2; i++) begin
			send_item((i % 2) ? ACT_LOAD_B : ACT_LOAD_A, elem_t'(v));
			v += $urandom_range(1, 900);
		end
		send_item(ACT_COMPUTE, elem_t'($urandom));
		no_idle = 1'b0;
		// flag must be clear again on the next compute
		send_item(ACT_COMPUTE, elem_t'($urandom));
	endtask

	task automatic test_random_rounds();
		int stop_at, step_max;
		stop_at = items_sent + RANDOM_ITEMS;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 2) == 0) set_op(OP_W'($urandom_range(0, 3)));
			no_idle = ($urandom_range(0, 5) == 0);
			case ($urandom_range(0, 2))
				0: step_max = 2;
				1: step_max = 300;
				default: step_max = 12000;
			endcase
			run_round($urandom_range(0, 8), step_max, $urandom_range(0, 3) == 0);
		end
		no_idle = 1'b0;
	endtask

	initial begin : result_checker
		int    gap;
		beat_t got;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (result_ch.valid !== 1'b1);
			got = '{result_ch.result_value, result_ch.is_last, result_ch.is_empty,
				result_ch.overflowed};
			if (expected_beats.size() == 0)
				report("unexpected result beat", '0, got);
			else if (got !== expected_beats[0])
				report("result mismatch", expected_beats.pop_front(), got);
			else
				void'(expected_beats.pop_front());
		end
	end

	initial begin
		item_ch.valid   = 1'b0;
		item_ch.action  = ACT_LOAD_A;
		item_ch.element = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_operations();
		test_unordered_loads();
		test_store_full();
		test_random_rounds();
		item_ch.valid <= 1'b0;
		wait_drained();
		repeat (2 * SET_DEPTH) @(posedge clk);
		if (mismatches == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

	initial begin
		#(2_000_000);
		$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: sorted_set_merge_operations.f
hw/rtl/ssm_pkg.sv
hw/rtl/ssm_if.sv
hw/rtl/ssm_ctrl.sv
hw/rtl/ssm_dp.sv
hw/rtl/sorted_set_merge_operations.sv
hw/rtl/ssm_checker.sv
tb/sv/tb_sorted_set_merge_operations.sv
